FILE: src/indexed_list_store_defines.svh
// Assertion macros for the list store.
// Each check is active in simulation and empty when SYNTH is defined.
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication: cons must hold whenever ante holds.
`define ILS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ILS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ILS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ILS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/ils_pkg.sv
package ils_pkg;

    localparam int DEPTH  = 64;
    localparam int WORD_W = 32;
    localparam int IDX_W  = 7;
    localparam int GRP    = 8;
    localparam int GROUPS = (DEPTH + GRP - 1) / GRP;

    localparam logic [IDX_W-1:0] DEPTH_FILL = IDX_W'(DEPTH);

    // command codes
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_EDIT   = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_DUMP   = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_BADIDX  = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    // cell row operations
    localparam logic [2:0] MODE_HOLD   = 3'd0;
    localparam logic [2:0] MODE_WRITE  = 3'd1;
    localparam logic [2:0] MODE_INSERT = 3'd2;
    localparam logic [2:0] MODE_DELETE = 3'd3;
    localparam logic [2:0] MODE_ROTATE = 3'd4;

    typedef struct packed {
        logic        [2:0]        command;
        logic signed [WORD_W-1:0] value;
        logic        [IDX_W-1:0]  position;
    } req_t;

    typedef struct packed {
        logic        [2:0]        status;
        logic signed [WORD_W-1:0] word;
        logic        [IDX_W-1:0]  where;
        logic        [IDX_W-1:0]  count;
        logic                     last;
    } rsp_t;

    // broadcast to every cell
    typedef struct packed {
        logic [2:0]        mode;
        logic [IDX_W-1:0]  pos;
        logic [IDX_W-1:0]  fill;
        logic [IDX_W-1:0]  last_idx;
        logic [WORD_W-1:0] val;
    } cell_cmd_t;

endpackage

FILE: src/ils_cell.sv
// One list slot. Takes its left or right neighbor, the head word, or the
// broadcast value, depending on the row operation and its own index.
module ils_cell (
    input  logic                             clk,
    input  logic [ils_pkg::IDX_W-1:0]        idx,
    input  ils_pkg::cell_cmd_t               cmd,
    input  logic [ils_pkg::WORD_W-1:0]       left,
    input  logic [ils_pkg::WORD_W-1:0]       right,
    input  logic [ils_pkg::WORD_W-1:0]       head,
    output logic [ils_pkg::WORD_W-1:0]       data,
    output logic [ils_pkg::WORD_W-1:0]       masked
);

    logic [ils_pkg::WORD_W-1:0] data_reg;
    logic [ils_pkg::WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.mode)
            ils_pkg::MODE_WRITE:
            begin
                if (idx == cmd.pos)
                    data_next = cmd.val;
            end
            ils_pkg::MODE_INSERT:
            begin
                priority if (idx == cmd.pos)
                    data_next = cmd.val;
                else if (idx > cmd.pos && idx <= cmd.fill)
                    data_next = left;
                else
                    data_next = data_reg;
            end
            ils_pkg::MODE_DELETE:
            begin
                if (idx >= cmd.pos && idx < cmd.last_idx)
                    data_next = right;
            end
            ils_pkg::MODE_ROTATE:
            begin
                priority if (idx < cmd.last_idx)
                    data_next = right;
                else if (idx == cmd.last_idx)
                    data_next = head;
                else
                    data_next = data_reg;
            end
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data   = data_reg;
    assign masked = (idx == cmd.pos) ? data_reg : '0;

endmodule

FILE: src/ils_row.sv
// Row of DEPTH cells plus a registered OR tree that picks out the entry
// at cmd.pos for delete (one level in the delete cycle, one after).
module ils_row (
    input  logic                        clk,
    input  ils_pkg::cell_cmd_t          cmd,
    output logic [ils_pkg::WORD_W-1:0]  head,
    output logic [ils_pkg::WORD_W-1:0]  gone
);

    logic [ils_pkg::WORD_W-1:0] data_w   [ils_pkg::DEPTH];
    logic [ils_pkg::WORD_W-1:0] masked_w [ils_pkg::DEPTH];
    logic [ils_pkg::WORD_W-1:0] grp_or   [ils_pkg::GROUPS];
    logic [ils_pkg::WORD_W-1:0] grp_reg  [ils_pkg::GROUPS];

    for (genvar k = 0; k < ils_pkg::DEPTH; k++)
    begin : g_cell
        logic [ils_pkg::WORD_W-1:0] left_w;
        logic [ils_pkg::WORD_W-1:0] right_w;

        if (k == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = data_w[k-1];
        end

        if (k == ils_pkg::DEPTH - 1)
        begin : g_end
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = data_w[k+1];
        end

        ils_cell u_cell (
            .clk    (clk),
            .idx    (ils_pkg::IDX_W'(k)),
            .cmd    (cmd),
            .left   (left_w),
            .right  (right_w),
            .head   (data_w[0]),
            .data   (data_w[k]),
            .masked (masked_w[k])
        );
    end

    always_comb
    begin
        for (int g = 0; g < ils_pkg::GROUPS; g++)
        begin
            grp_or[g] = '0;
            for (int j = 0; j < ils_pkg::GRP; j++)
            begin
                if (g * ils_pkg::GRP + j < ils_pkg::DEPTH)
                    grp_or[g] = grp_or[g] | masked_w[g * ils_pkg::GRP + j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mode == ils_pkg::MODE_DELETE)
        begin
            for (int g = 0; g < ils_pkg::GROUPS; g++)
                grp_reg[g] <= grp_or[g];
        end
    end

    always_comb
    begin
        gone = '0;
        for (int g = 0; g < ils_pkg::GROUPS; g++)
            gone = gone | grp_reg[g];
    end

    assign head = data_w[0];

endmodule

FILE: src/indexed_list_store.sv
// Ordered list of up to 64 signed 32-bit words kept in a row of cells, one
// entry per cell, with the length in a counter. A request carries a command:
// add, insert, edit, delete, dump or clear. Insert and delete move every
// later entry one cell up or down together. Add, insert, edit, clear and
// every rejected request give their one response in the cycle after
// acceptance, and the next request is taken in that same cycle when the
// response slot is free or being drained: one request per cycle. Delete
// passes the removed word through a registered OR tree over the cells and
// then the response register before it is shown. For dump the row rotates
// by one cell per cycle toward cell 0, each response reads cell 0, and
// after fill steps the list is back in its original order; response stalls
// hold the rotation. A full list, an index past the end, an empty list or
// an unknown command give an error status and change nothing.
// Entries hold no reset value; only entries below the length are ever read.
`include "indexed_list_store_defines.svh"

module indexed_list_store (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ils_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ils_pkg::rsp_t rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEL  = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [ils_pkg::IDX_W-1:0]  fill_reg,  fill_next;
    logic [ils_pkg::IDX_W-1:0]  pos_reg,   pos_next;
    logic [ils_pkg::IDX_W-1:0]  idx_reg,   idx_next;
    logic                       out_valid_reg, out_valid_next;
    ils_pkg::rsp_t              out_reg,   out_next;

    ils_pkg::cell_cmd_t         cmd;
    logic [ils_pkg::WORD_W-1:0] head;
    logic [ils_pkg::WORD_W-1:0] gone;
    logic                       out_free;
    logic                       accept;
    logic [ils_pkg::IDX_W-1:0]  fill_m1;

    // response slot empties this cycle or is already empty
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = !(state_reg == S_IDLE && out_free);
    assign accept    = req_valid && !req_stall;
    assign fill_m1   = fill_reg - 1'b1;

    ils_row u_row (
        .clk  (clk),
        .cmd  (cmd),
        .head (head),
        .gone (gone)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;

        cmd.mode     = ils_pkg::MODE_HOLD;
        cmd.pos      = req.position;
        cmd.fill     = fill_reg;
        cmd.last_idx = fill_m1;
        cmd.val      = req.value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // default response with OK status and the current count, list unchanged
                    out_valid_next  = 1'b1;
                    out_next.status = ils_pkg::ST_OK;
                    out_next.word   = '0;
                    out_next.where  = '0;
                    out_next.count  = fill_reg;
                    out_next.last   = 1'b1;

                    unique case (req.command)
                        ils_pkg::CMD_ADD:
                        begin
                            if (fill_reg >= ils_pkg::DEPTH_FILL)
                                out_next.status = ils_pkg::ST_FULL;
                            else
                            begin
                                cmd.mode       = ils_pkg::MODE_WRITE;
                                cmd.pos        = fill_reg;
                                fill_next      = fill_reg + 1'b1;
                                out_next.word  = req.value;
                                out_next.where = fill_reg;
                                out_next.count = fill_reg + 1'b1;
                            end
                        end
                        ils_pkg::CMD_INSERT:
                        begin
                            priority if (fill_reg >= ils_pkg::DEPTH_FILL)
                                out_next.status = ils_pkg::ST_FULL;
                            else if (req.position > fill_reg)
                                out_next.status = ils_pkg::ST_BADIDX;
                            else
                            begin
                                cmd.mode       = ils_pkg::MODE_INSERT;
                                fill_next      = fill_reg + 1'b1;
                                out_next.word  = req.value;
                                out_next.where = req.position;
                                out_next.count = fill_reg + 1'b1;
                            end
                        end
                        ils_pkg::CMD_EDIT:
                        begin
                            priority if (fill_reg == '0)
                                out_next.status = ils_pkg::ST_EMPTY;
                            else if (req.position >= fill_reg)
                                out_next.status = ils_pkg::ST_BADIDX;
                            else
                            begin
                                cmd.mode       = ils_pkg::MODE_WRITE;
                                out_next.word  = req.value;
                                out_next.where = req.position;
                            end
                        end
                        ils_pkg::CMD_DELETE:
                        begin
                            priority if (fill_reg == '0)
                                out_next.status = ils_pkg::ST_EMPTY;
                            else if (req.position >= fill_reg)
                                out_next.status = ils_pkg::ST_BADIDX;
                            else
                            begin
                                // capture the entry and close the gap now;
                                // the word goes through the OR-tree and response registers
                                cmd.mode       = ils_pkg::MODE_DELETE;
                                fill_next      = fill_m1;
                                pos_next       = req.position;
                                out_valid_next = 1'b0;
                                state_next     = S_DEL;
                            end
                        end
                        ils_pkg::CMD_DUMP:
                        begin
                            if (fill_reg == '0)
                            begin
                                out_next.status = ils_pkg::ST_EMPTY;
                                out_next.count  = '0;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                idx_next       = '0;
                                state_next     = S_DUMP;
                            end
                        end
                        ils_pkg::CMD_CLEAR:
                        begin
                            fill_next      = '0;
                            out_next.count = '0;
                        end
                        default:
                            out_next.status = ils_pkg::ST_INVALID;
                    endcase
                end
            end
            S_DEL:
            begin
                out_valid_next  = 1'b1;
                out_next.status = ils_pkg::ST_OK;
                out_next.word   = gone;
                out_next.where  = pos_reg;
                out_next.count  = fill_reg;
                out_next.last   = 1'b1;
                state_next      = S_IDLE;
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    cmd.mode        = ils_pkg::MODE_ROTATE;
                    out_valid_next  = 1'b1;
                    out_next.status = ils_pkg::ST_OK;
                    out_next.word   = head;
                    out_next.where  = idx_reg;
                    out_next.count  = fill_reg;
                    out_next.last   = (idx_reg == fill_m1);
                    idx_next        = idx_reg + 1'b1;
                    if (idx_reg == fill_m1)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `ILS_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= ils_pkg::DEPTH_FILL)
    `ILS_ASSERT_NEXT(a_del_shows, clk, rst_n, state_reg == S_DEL, rsp_valid)
    `ILS_ASSERT_IMP(a_dump_idx, clk, rst_n, state_reg == S_DUMP, idx_reg < fill_reg)
    `ILS_ASSERT_NEXT(a_clear_empties, clk, rst_n, accept && req.command == ils_pkg::CMD_CLEAR, fill_reg == '0)

endmodule
